### hw/rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants of the swap sequence generator.
// ----------------------------------------------------------------------------
package pss_pkg;

   localparam int ID_W      = 16;
   localparam int POS_W     = 6;
   localparam int MAX_OUT   = 63;
   localparam int OUT_CNT_W = 6;

   typedef struct packed {
      logic [ID_W-1:0] source_id;
      logic [ID_W-1:0] target_id;
      logic            final_element;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] first_pos;
      logic [POS_W-1:0] second_pos;
      logic             final_swap;
      logic             no_swaps;
      logic             overflowed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_BASE,
      ST_PROBE,
      ST_CHECK,
      ST_DONE
   } back_state_type;

endpackage

### hw/rtl/pss_ram.sv
// ----------------------------------------------------------------------------
// pss_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/pss_front.sv
// ----------------------------------------------------------------------------
// pss_front
// Load side: takes id pairs, writes both stores, counts the load and hands
// a run command to the queue when the final request arrives.
// ----------------------------------------------------------------------------
module pss_front #(
   parameter int ENTRIES = 64,
   localparam int IDX_W  = $clog2(ENTRIES),
   localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pss_pkg::req_type         req_data,
   input  logic                     blocked,
   output logic                     ld_we,
   output logic [IDX_W-1:0]         ld_addr,
   output logic [pss_pkg::ID_W-1:0] ld_src,
   output logic [pss_pkg::ID_W-1:0] ld_tgt,
   output logic                     push,
   output logic [CNT_W-1:0]         push_n,
   output logic                     push_ovf
);

   logic [CNT_W-1:0] load_count_ff, load_count_in;
   logic             ovf_seen_ff, ovf_seen_in;
   logic             accept;
   logic             has_room;
   logic [CNT_W-1:0] count_inc;

   assign req_stall = blocked;
   assign accept    = req_valid && !blocked;
   assign has_room  = load_count_ff < CNT_W'(ENTRIES);
   assign count_inc = load_count_ff + CNT_W'(1);

   assign ld_we    = accept && has_room;
   assign ld_addr  = load_count_ff[IDX_W-1:0];
   assign ld_src   = req_data.source_id;
   assign ld_tgt   = req_data.target_id;
   assign push     = accept && req_data.final_element;
   assign push_n   = has_room ? count_inc : load_count_ff;
   assign push_ovf = ovf_seen_ff || !has_room;

   always_comb begin
      load_count_in = load_count_ff;
      ovf_seen_in   = ovf_seen_ff;
      if (accept) begin
         if (req_data.final_element) begin
            load_count_in = '0;
            ovf_seen_in   = 1'b0;
         end else if (has_room) begin
            load_count_in = count_inc;
         end else begin
            ovf_seen_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         ovf_seen_ff   <= 1'b0;
      end else begin
         load_count_ff <= load_count_in;
         ovf_seen_ff   <= ovf_seen_in;
      end
   end

endmodule

### hw/rtl/pss_queue.sv
// ----------------------------------------------------------------------------
// pss_queue
// Two-entry command queue between the load side and the search engine.
// ----------------------------------------------------------------------------
module pss_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   logic [1:0]       count_ff, count_in;
   logic [WIDTH-1:0] slot0_ff, slot0_in;
   logic [WIDTH-1:0] slot1_ff, slot1_in;

   assign head_valid = count_ff != 2'd0;
   assign head_data  = slot0_ff;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case ({push, pop})
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot0_in = push_data;
            end else begin
               slot1_in = push_data;
            end
            count_in = count_ff + 2'd1;
         end
         2'b11: begin
            // head leaves as the new command enters
            if (count_ff == 2'd1) begin
               slot0_in = push_data;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

### hw/rtl/pss_back.sv
// ----------------------------------------------------------------------------
// pss_back
// Search engine: walks the positions, probes the working copy for the goal
// id, applies swaps and delivers them through the response register.
// ----------------------------------------------------------------------------
module pss_back #(
   parameter int ENTRIES = 64,
   localparam int IDX_W  = $clog2(ENTRIES),
   localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  logic [CNT_W-1:0]         cmd_n,
   input  logic                     cmd_ovf,
   output logic                     cmd_pop,
   output logic                     busy,
   output logic [IDX_W-1:0]         work_rd_addr,
   input  logic [pss_pkg::ID_W-1:0] work_rd_data,
   output logic [IDX_W-1:0]         goal_rd_addr,
   input  logic [pss_pkg::ID_W-1:0] goal_rd_data,
   output logic                     sw_we,
   output logic [IDX_W-1:0]         sw_addr,
   output logic [pss_pkg::ID_W-1:0] sw_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output pss_pkg::rsp_type         rsp_data
);

   pss_pkg::back_state_type state_ff, state_in;

   logic [IDX_W-1:0]               i_ff, i_in;
   logic [IDX_W-1:0]               j_ff, j_in;
   logic [CNT_W-1:0]               n_ff, n_in;
   logic                           ovf_ff, ovf_in;
   logic [pss_pkg::ID_W-1:0]       wi_ff, wi_in;
   logic [pss_pkg::ID_W-1:0]       gi_ff, gi_in;
   logic [pss_pkg::OUT_CNT_W-1:0]  count_ff, count_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [pss_pkg::POS_W-1:0]      pend_first_ff, pend_first_in;
   logic [pss_pkg::POS_W-1:0]      pend_second_ff, pend_second_in;
   logic                           out_valid_ff, out_valid_in;
   pss_pkg::rsp_type               out_data_ff, out_data_in;

   logic                           out_free;
   logic [CNT_W-1:0]               i_next;
   logic [CNT_W-1:0]               j_next;
   logic                           last_i;
   logic                           room_left;
   logic [pss_pkg::POS_W+IDX_W-1:0] i_wide;
   logic [pss_pkg::POS_W+IDX_W-1:0] j_wide;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign i_next    = CNT_W'(i_ff) + CNT_W'(1);
   assign j_next    = CNT_W'(j_ff) + CNT_W'(1);
   assign last_i    = i_next == n_ff;
   assign room_left = count_ff != pss_pkg::OUT_CNT_W'(pss_pkg::MAX_OUT);
   // positions are reported modulo 64
   assign i_wide    = {{pss_pkg::POS_W{1'b0}}, i_ff};
   assign j_wide    = {{pss_pkg::POS_W{1'b0}}, j_ff};

   assign busy         = state_ff != pss_pkg::ST_IDLE;
   assign goal_rd_addr = i_ff;
   assign work_rd_addr = (state_ff == pss_pkg::ST_FETCH) ? i_ff : j_ff;
   assign sw_addr      = j_ff;
   assign sw_data      = wi_ff;
   assign rsp_valid    = out_valid_ff;
   assign rsp_data     = out_data_ff;

   always_comb begin
      state_in       = state_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      n_in           = n_ff;
      ovf_in         = ovf_ff;
      wi_in          = wi_ff;
      gi_in          = gi_ff;
      count_in       = count_ff;
      pend_valid_in  = pend_valid_ff;
      pend_first_in  = pend_first_ff;
      pend_second_in = pend_second_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      out_data_in    = out_data_ff;
      cmd_pop        = 1'b0;
      sw_we          = 1'b0;

      unique case (state_ff)
         pss_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop       = 1'b1;
               n_in          = cmd_n;
               ovf_in        = cmd_ovf;
               i_in          = '0;
               count_in      = '0;
               pend_valid_in = 1'b0;
               state_in      = pss_pkg::ST_FETCH;
            end
         end
         pss_pkg::ST_FETCH: begin
            state_in = pss_pkg::ST_BASE;
         end
         pss_pkg::ST_BASE: begin
            wi_in = work_rd_data;
            gi_in = goal_rd_data;
            if (work_rd_data == goal_rd_data || last_i) begin
               if (last_i) begin
                  state_in = pss_pkg::ST_DONE;
               end else begin
                  i_in     = i_next[IDX_W-1:0];
                  state_in = pss_pkg::ST_FETCH;
               end
            end else begin
               j_in     = i_next[IDX_W-1:0];
               state_in = pss_pkg::ST_PROBE;
            end
         end
         pss_pkg::ST_PROBE: begin
            state_in = pss_pkg::ST_CHECK;
         end
         pss_pkg::ST_CHECK: begin
            if (work_rd_data == gi_ff) begin
               // hold the match while the older swap cannot leave
               if (!(room_left && pend_valid_ff && !out_free)) begin
                  sw_we = 1'b1;
                  if (room_left) begin
                     if (pend_valid_ff) begin
                        out_valid_in           = 1'b1;
                        out_data_in.first_pos  = pend_first_ff;
                        out_data_in.second_pos = pend_second_ff;
                        out_data_in.final_swap = 1'b0;
                        out_data_in.no_swaps   = 1'b0;
                        out_data_in.overflowed = ovf_ff;
                     end
                     pend_valid_in  = 1'b1;
                     pend_first_in  = i_wide[pss_pkg::POS_W-1:0];
                     pend_second_in = j_wide[pss_pkg::POS_W-1:0];
                     count_in       = count_ff + pss_pkg::OUT_CNT_W'(1);
                  end
                  if (last_i) begin
                     state_in = pss_pkg::ST_DONE;
                  end else begin
                     i_in     = i_next[IDX_W-1:0];
                     state_in = pss_pkg::ST_FETCH;
                  end
               end
            end else if (j_next == n_ff) begin
               // id not found: no swap at this position
               if (last_i) begin
                  state_in = pss_pkg::ST_DONE;
               end else begin
                  i_in     = i_next[IDX_W-1:0];
                  state_in = pss_pkg::ST_FETCH;
               end
            end else begin
               j_in     = j_next[IDX_W-1:0];
               state_in = pss_pkg::ST_PROBE;
            end
         end
         pss_pkg::ST_DONE: begin
            if (out_free) begin
               out_valid_in           = 1'b1;
               out_data_in.first_pos  = pend_valid_ff ? pend_first_ff : '0;
               out_data_in.second_pos = pend_valid_ff ? pend_second_ff : '0;
               out_data_in.final_swap = 1'b1;
               out_data_in.no_swaps   = !pend_valid_ff;
               out_data_in.overflowed = ovf_ff;
               pend_valid_in          = 1'b0;
               state_in               = pss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pss_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pss_pkg::ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      i_ff           <= i_in;
      j_ff           <= j_in;
      n_ff           <= n_in;
      ovf_ff         <= ovf_in;
      wi_ff          <= wi_in;
      gi_ff          <= gi_in;
      pend_first_ff  <= pend_first_in;
      pend_second_ff <= pend_second_in;
      out_data_ff    <= out_data_in;
   end

   a_pend_counted: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (count_ff != '0))
      else $error("held swap without a count");

   a_i_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pss_pkg::ST_IDLE) |-> (CNT_W'(i_ff) < n_ff))
      else $error("position beyond the load");

   a_j_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pss_pkg::ST_PROBE || state_ff == pss_pkg::ST_CHECK)
      |-> (j_ff > i_ff && CNT_W'(j_ff) < n_ff))
      else $error("probe outside the search window");

   a_done_final: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pss_pkg::ST_DONE && out_free)
      |=> (state_ff == pss_pkg::ST_IDLE && out_valid_ff && out_data_ff.final_swap))
      else $error("run ended without a final response");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.no_swaps)
      |-> (out_data_ff.final_swap && out_data_ff.first_pos == '0
           && out_data_ff.second_pos == '0))
      else $error("malformed empty response");

endmodule

### hw/rtl/permutation_swap_sequence_top.sv
// ----------------------------------------------------------------------------
// permutation_swap_sequence_top
// Swap sequence generator turning a loaded id sequence into a target one.
// ----------------------------------------------------------------------------
// Requests (req_valid / req_stall / req_data) carry one source and target id
// per position; final_element marks the last position and starts the run.
// Loading takes one request per cycle while req_stall is low and writes both
// stores. Requests past ENTRIES are dropped and flagged in overflowed.
// After the final request req_stall stays high until the search engine has
// finished the run. Each position is fetched from both stores and then each
// entry above it is probed in turn, every read going through the registered
// store read.
// Responses (rsp_valid / rsp_stall / rsp_data) give each swap (first_pos,
// second_pos) in order, the last with final_swap set, or one response with
// no_swaps set. A swap leaves one found swap later, through an output
// register; a stalled response holds and only pauses the search.
// Reset clears the load count, overflow flag, queue and engine; the stores
// need no clearing since a run reads only entries of its own load.
// ----------------------------------------------------------------------------
module permutation_swap_sequence_top #(
   parameter int ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pss_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic                     ld_we;
   logic [IDX_W-1:0]         ld_addr;
   logic [pss_pkg::ID_W-1:0] ld_src;
   logic [pss_pkg::ID_W-1:0] ld_tgt;
   logic                     push;
   logic [CNT_W-1:0]         push_n;
   logic                     push_ovf;
   logic                     cmd_valid;
   logic [CNT_W:0]           cmd_data;
   logic                     cmd_pop;
   logic                     back_busy;
   logic                     blocked;
   logic [IDX_W-1:0]         work_rd_addr;
   logic [pss_pkg::ID_W-1:0] work_rd_data;
   logic [IDX_W-1:0]         goal_rd_addr;
   logic [pss_pkg::ID_W-1:0] goal_rd_data;
   logic                     sw_we;
   logic [IDX_W-1:0]         sw_addr;
   logic [pss_pkg::ID_W-1:0] sw_data;
   logic                     work_we;
   logic [IDX_W-1:0]         work_wr_addr;
   logic [pss_pkg::ID_W-1:0] work_wr_data;

   // stores are shared, so no new load while a run is queued or active
   assign blocked = cmd_valid || back_busy;

   // loading and swapping never overlap
   assign work_we      = ld_we || sw_we;
   assign work_wr_addr = ld_we ? ld_addr : sw_addr;
   assign work_wr_data = ld_we ? ld_src : sw_data;

   pss_front #(
      .ENTRIES (ENTRIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .blocked   (blocked),
      .ld_we     (ld_we),
      .ld_addr   (ld_addr),
      .ld_src    (ld_src),
      .ld_tgt    (ld_tgt),
      .push      (push),
      .push_n    (push_n),
      .push_ovf  (push_ovf)
   );

   pss_queue #(
      .WIDTH (CNT_W + 1)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_ovf, push_n}),
      .pop        (cmd_pop),
      .head_valid (cmd_valid),
      .head_data  (cmd_data)
   );

   pss_ram #(
      .WIDTH (pss_pkg::ID_W),
      .DEPTH (ENTRIES)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (work_we),
      .wr_addr (work_wr_addr),
      .wr_data (work_wr_data),
      .rd_addr (work_rd_addr),
      .rd_data (work_rd_data)
   );

   pss_ram #(
      .WIDTH (pss_pkg::ID_W),
      .DEPTH (ENTRIES)
   ) u_goal_ram (
      .clock   (clock),
      .wr_en   (ld_we),
      .wr_addr (ld_addr),
      .wr_data (ld_tgt),
      .rd_addr (goal_rd_addr),
      .rd_data (goal_rd_data)
   );

   pss_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_n        (cmd_data[CNT_W-1:0]),
      .cmd_ovf      (cmd_data[CNT_W]),
      .cmd_pop      (cmd_pop),
      .busy         (back_busy),
      .work_rd_addr (work_rd_addr),
      .work_rd_data (work_rd_data),
      .goal_rd_addr (goal_rd_addr),
      .goal_rd_data (goal_rd_data),
      .sw_we        (sw_we),
      .sw_addr      (sw_addr),
      .sw_data      (sw_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives id-sequence loads into the swap sequence generator and checks each
// swap response against an in-bench predictor of the search, in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int ENTRIES      = 64;
   localparam int ITEM_TARGET  = 410;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 32;
   localparam int RESET_CYCLES = 8;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pss_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pss_pkg::rsp_type rsp_data;

   // predictor state: shadow copies of both stores
   logic [pss_pkg::ID_W-1:0] shadow_work [ENTRIES];
   logic [pss_pkg::ID_W-1:0] shadow_goal [ENTRIES];
   int                       shadow_count = 0;
   logic                     shadow_spill = 1'b0;
   pss_pkg::rsp_type         swap_queue [$];

   logic [pss_pkg::ID_W-1:0] src_seq [$];
   logic [pss_pkg::ID_W-1:0] tgt_seq [$];
   int                       items_sent    = 0;
   int unsigned              cycle_count   = 0;
   bit                       steady_req    = 1'b0;
   bit                       steady_rsp    = 1'b0;
   bit                       mismatch_seen = 1'b0;

   permutation_swap_sequence_top #(.ENTRIES(ENTRIES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d swaps outstanding", $time, swap_queue.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // store one request; on the final one, run the search and queue its swaps
   function automatic void predict_swaps(input pss_pkg::req_type item);
      pss_pkg::rsp_type         held;
      bit                       have_held;
      int                       emitted;
      int                       n;
      logic [pss_pkg::ID_W-1:0] t;
      if (shadow_count < ENTRIES) begin
         shadow_work[shadow_count] = item.source_id;
         shadow_goal[shadow_count] = item.target_id;
         shadow_count++;
      end else begin
         shadow_spill = 1'b1;
      end
      if (!item.final_element)
         return;
      n         = shadow_count;
      emitted   = 0;
      have_held = 1'b0;
      held      = '0;
      for (int i = 0; i < n; i++) begin
         for (int j = i; j < n; j++) begin
            if (shadow_work[j] == shadow_goal[i]) begin
               if (j != i) begin
                  t              = shadow_work[i];
                  shadow_work[i] = shadow_work[j];
                  shadow_work[j] = t;
                  // later swaps still apply but are not reported past the cap
                  if (emitted < pss_pkg::MAX_OUT) begin
                     if (have_held)
                        swap_queue.push_back(held);
                     held            = '0;
                     held.first_pos  = pss_pkg::POS_W'(i);
                     held.second_pos = pss_pkg::POS_W'(j);
                     held.overflowed = shadow_spill;
                     have_held       = 1'b1;
                     emitted++;
                  end
               end
               break;
            end
         end
      end
      if (have_held) begin
         held.final_swap = 1'b1;
         swap_queue.push_back(held);
      end else begin
         held            = '0;
         held.final_swap = 1'b1;
         held.no_swaps   = 1'b1;
         held.overflowed = shadow_spill;
         swap_queue.push_back(held);
      end
      shadow_count = 0;
      shadow_spill = 1'b0;
   endfunction

   task automatic send_item(input pss_pkg::req_type item);
      int gap;
      gap = steady_req ? 0 : int'($urandom_range(0, 4));
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_swaps(item);
      items_sent++;
   endtask

   task automatic send_run();
      pss_pkg::req_type item;
      for (int k = 0; k < src_seq.size(); k++) begin
         item.source_id     = src_seq[k];
         item.target_id     = tgt_seq[k];
         item.final_element = (k == src_seq.size() - 1);
         send_item(item);
      end
   endtask

   // odd stride modulo 2^16 keeps the ids distinct
   function automatic void fill_distinct(input int n);
      logic [pss_pkg::ID_W-1:0] base;
      logic [pss_pkg::ID_W-1:0] stride;
      base   = pss_pkg::ID_W'($urandom);
      stride = pss_pkg::ID_W'($urandom) | pss_pkg::ID_W'(1);
      src_seq.delete();
      for (int k = 0; k < n; k++)
         src_seq.push_back(pss_pkg::ID_W'(base + stride * pss_pkg::ID_W'(k)));
   endfunction

   function automatic void fill_repeats(input int n);
      logic [pss_pkg::ID_W-1:0] base;
      base = pss_pkg::ID_W'($urandom);
      src_seq.delete();
      for (int k = 0; k < n; k++)
         src_seq.push_back(pss_pkg::ID_W'(base + pss_pkg::ID_W'($urandom_range(0, 2))));
   endfunction

   function automatic void shuffle_target();
      int                       pick;
      logic [pss_pkg::ID_W-1:0] t;
      tgt_seq = src_seq;
      for (int k = tgt_seq.size() - 1; k > 0; k--) begin
         pick          = int'($urandom_range(0, k));
         t             = tgt_seq[k];
         tgt_seq[k]    = tgt_seq[pick];
         tgt_seq[pick] = t;
      end
   endfunction

   function automatic void noise_target();
      tgt_seq.delete();
      for (int k = 0; k < src_seq.size(); k++)
         tgt_seq.push_back(pss_pkg::ID_W'($urandom));
   endfunction

   task automatic test_single_item();
      src_seq = '{16'h0000};
      tgt_seq = '{16'h0000};
      send_run();
      // id never found in a one-entry load
      src_seq = '{16'hffff};
      tgt_seq = '{16'h0000};
      send_run();
   endtask

   task automatic test_already_matched();
      fill_distinct(3);
      tgt_seq = src_seq;
      send_run();
   endtask

   task automatic test_reversal();
      src_seq = '{16'hffff, 16'h0000, 16'haaaa, 16'h5555};
      tgt_seq = '{16'h5555, 16'haaaa, 16'h0000, 16'hffff};
      send_run();
   endtask

   task automatic test_missing_id();
      src_seq = '{16'h0001, 16'h0002, 16'h0003};
      tgt_seq = '{16'h0003, 16'h0004, 16'h0001};
      send_run();
   endtask

   task automatic test_duplicates();
      src_seq = '{16'h0007, 16'h0007, 16'h0009};
      tgt_seq = '{16'h0009, 16'h0007, 16'h0007};
      send_run();
      src_seq = '{16'h0005, 16'h0009, 16'h0005};
      tgt_seq = '{16'h0005, 16'h0005, 16'h0009};
      send_run();
   endtask

   task automatic test_capacity();
      fill_distinct(ENTRIES);
      shuffle_target();
      send_run();
      // final request lands past capacity and is dropped
      fill_distinct(ENTRIES + 1);
      shuffle_target();
      send_run();
      fill_distinct(ENTRIES + int'($urandom_range(2, 6)));
      shuffle_target();
      send_run();
   endtask

   task automatic test_random_runs();
      int shape;
      int len;
      while (items_sent < ITEM_TARGET) begin
         steady_req = ($urandom_range(0, 3) == 0);
         steady_rsp = ($urandom_range(0, 3) == 0);
         shape      = int'($urandom_range(0, 99));
         len        = int'($urandom_range(1, 10));
         if ($urandom_range(0, 39) == 0)
            len = ENTRIES + int'($urandom_range(0, 4));
         if (shape < 70) begin
            fill_distinct(len);
            shuffle_target();
            // broken permutation now and then
            if (shape < 10)
               tgt_seq[$urandom_range(0, len - 1)] = pss_pkg::ID_W'($urandom);
         end else if (shape < 85) begin
            fill_repeats(len);
            shuffle_target();
         end else begin
            fill_distinct(len);
            noise_target();
         end
         send_run();
      end
   endtask

   // response side: random hold before each response, sometimes none
   initial begin
      int hold;
      forever begin
         hold = steady_rsp ? 0 : int'($urandom_range(0, 4));
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic report_field(input string field, input int want, input int got);
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatch_seen = 1'b1;
   endtask

   always @(posedge clock) begin : check_swaps
      pss_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (swap_queue.size() == 0) begin
            $display("%0t: unexpected response, got %h", $time, rsp_data);
            mismatch_seen = 1'b1;
         end else begin
            want = swap_queue.pop_front();
            if (rsp_data.first_pos !== want.first_pos)
               report_field("first_pos", int'(want.first_pos), int'(rsp_data.first_pos));
            if (rsp_data.second_pos !== want.second_pos)
               report_field("second_pos", int'(want.second_pos), int'(rsp_data.second_pos));
            if (rsp_data.final_swap !== want.final_swap)
               report_field("final_swap", int'(want.final_swap), int'(rsp_data.final_swap));
            if (rsp_data.no_swaps !== want.no_swaps)
               report_field("no_swaps", int'(want.no_swaps), int'(rsp_data.no_swaps));
            if (rsp_data.overflowed !== want.overflowed)
               report_field("overflowed", int'(want.overflowed), int'(rsp_data.overflowed));
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_single_item();
      test_already_matched();
      test_reversal();
      test_missing_id();
      test_duplicates();
      test_capacity();
      test_random_runs();
      req_valid <= 1'b0;
      while (swap_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!mismatch_seen)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
